// File: rtl/wrc_pkg.sv
// wrc_pkg: representation codes and field constants for the word converter
// used by word_repr_converter_unit
`timescale 1ns / 1ps
`default_nettype none
package wrc_pkg;
    typedef enum logic [1:0] {
        REPR_ANY = 2'd0,
        REPR_U64 = 2'd1,
        REPR_I64 = 2'd2,
        REPR_F64 = 2'd3
    } t_repr;

    localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;
    localparam logic [10:0] EXP_BIAS = 11'd1023;
    localparam logic [10:0] EXP_MAX  = 11'h7FF;
endpackage
`default_nettype wire

// File: rtl/word_repr_converter_unit.sv
// word_repr_converter_unit: converts one 64-bit word between untyped, unsigned,
// signed and binary64 representations; depends on wrc_pkg
`timescale 1ns / 1ps
`default_nettype none
// One item enters per cycle when the result register is free or being taken.
// An accepted item is held in an input register, converted by one pass of
// combinational logic (leading-one search, shift, round, saturate) and lands in
// the result register when that is free or being taken: one item per cycle while
// not stalled. Integer to double rounds to nearest even and raises inexact;
// double to integer truncates, saturates, NaN gives zero; raises invalid/inexact.
module word_repr_converter_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [63:0] s_axis_tdata,   // value
    input  wire  [3:0]  s_axis_tuser,   // from_repr [1:0], to_repr [3:2]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [63:0] m_axis_tdata,   // converted
    output logic [1:0]  m_axis_tuser    // invalid [0], inexact [1]
);
    logic        r_in_vld;
    logic [63:0] r_val;
    logic [1:0]  r_from, r_to;
    logic        r_out_vld;
    logic [63:0] r_res;
    logic        r_inv, r_inx;

    logic        adv_in, adv_out;
    assign adv_out = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || adv_out;
    assign adv_in = s_axis_tvalid && s_axis_tready;

    // integer to double
    logic        i_neg;
    logic [63:0] i_mag, i_norm;
    logic [5:0]  i_lz;
    logic [52:0] i_keep;
    logic [53:0] i_rnd;
    logic        i_g, i_st;
    logic [10:0] i_exp;
    logic [63:0] i_res;

    // double to integer
    logic        d_neg, d_big;
    logic [10:0] d_e;
    logic [51:0] d_frac;
    logic [5:0]  d_ue;
    logic [52:0] d_sig;
    logic [115:0] d_sh;
    logic [63:0] d_mag;
    logic        d_frac_lost;
    logic [63:0] d_res;
    logic        d_inv, d_inx;

    logic [63:0] n_res;
    logic        n_inv, n_inx;

    always_comb begin
        i_neg = (r_from == wrc_pkg::REPR_I64) && r_val[63];
        i_mag = i_neg ? (64'd0 - r_val) : r_val;
        i_lz = 6'd0;
        for (int k = 0; k < 64; k++) begin
            if (i_mag[k]) i_lz = 6'(63 - k);
        end
        i_norm = i_mag << i_lz;
        i_keep = i_norm[63:11];
        i_g    = i_norm[10];
        i_st   = |i_norm[9:0];
        i_rnd  = {1'b0, i_keep} + 54'((i_g && (i_st || i_keep[0])) ? 1 : 0);
        i_exp  = 11'd1086 - 11'(i_lz) + 11'(i_rnd[53]);
        if (i_mag == 64'd0) begin
            i_res = 64'd0;
        end else begin
            i_res = {i_neg, i_exp, (i_rnd[53] ? i_rnd[52:1] : i_rnd[51:0])};
        end
    end

    always_comb begin
        d_neg  = r_val[63];
        d_e    = r_val[62:52];
        d_frac = r_val[51:0];
        // only meaningful for exponents in the integer range, where it fits 6 bits
        d_ue   = 6'(d_e - wrc_pkg::EXP_BIAS);
        d_sig  = {1'b1, d_frac};
        d_big  = (d_e == wrc_pkg::EXP_MAX) || (d_e >= 11'd1087);
        d_mag  = 64'd0;
        d_sh   = 116'd0;
        d_frac_lost = 1'b0;
        if (d_e == 11'd0) begin
            d_frac_lost = d_frac != 52'd0;
        end else if (d_e < wrc_pkg::EXP_BIAS) begin
            d_frac_lost = 1'b1;
        end else if (!d_big) begin
            // sig placed with binary point at bit 52
            d_sh = {63'd0, d_sig} << d_ue;
            d_mag = d_sh[115:52];
            d_frac_lost = |d_sh[51:0];
        end
        d_inv = 1'b0;
        d_inx = d_frac_lost;
        d_res = d_mag;
        if (d_e == wrc_pkg::EXP_MAX && d_frac != 52'd0) begin
            d_inv = 1'b1; d_inx = 1'b0; d_res = 64'd0;
        end else if (r_to == wrc_pkg::REPR_I64) begin
            if (d_neg) begin
                if (d_big || d_mag > wrc_pkg::SIGN_BIT) begin
                    d_inv = 1'b1; d_inx = 1'b0; d_res = wrc_pkg::SIGN_BIT;
                end else begin
                    d_res = 64'd0 - d_mag;
                end
            end else if (d_big || d_mag[63]) begin
                d_inv = 1'b1; d_inx = 1'b0; d_res = wrc_pkg::SIGN_BIT - 64'd1;
            end
        end else begin
            if (d_neg) begin
                d_res = 64'd0;
                if (d_big || d_mag != 64'd0) begin
                    d_inv = 1'b1; d_inx = 1'b0;
                end
            end else if (d_big) begin
                d_inv = 1'b1; d_inx = 1'b0; d_res = '1;
            end
        end
    end

    always_comb begin
        n_res = r_val;
        n_inv = 1'b0;
        n_inx = 1'b0;
        if (r_from != r_to && r_from != wrc_pkg::REPR_ANY && r_to != wrc_pkg::REPR_ANY) begin
            if (r_to == wrc_pkg::REPR_F64) begin
                n_res = i_res;
                n_inx = i_g || i_st;
            end else if (r_from == wrc_pkg::REPR_F64) begin
                n_res = d_res;
                n_inv = d_inv;
                n_inx = d_inx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (adv_in) r_in_vld <= 1'b1;
            else if (adv_out) r_in_vld <= 1'b0;
            if (adv_out) r_out_vld <= 1'b1;
            else if (m_axis_tready) r_out_vld <= 1'b0;
        end
        if (adv_in) begin
            r_val  <= s_axis_tdata;
            r_from <= s_axis_tuser[1:0];
            r_to   <= s_axis_tuser[3:2];
        end
        if (adv_out) begin
            r_res <= n_res;
            r_inv <= n_inv;
            r_inx <= n_inx;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_res;
    assign m_axis_tuser  = {r_inx, r_inv};

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !m_axis_tready |=> r_out_vld && $stable(r_res))
        else $error("result changed while stalled");
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> !(r_inv && r_inx))
        else $error("invalid and inexact both set");
    a_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv_out |=> r_out_vld)
        else $error("result lost");
endmodule
`default_nettype wire
